// ===== design/dds_tone_burst_generator_defines.svh =====
// Assertion macros for the tone-burst generator; they expect clk and arst_n in scope.
`ifndef DDS_TONE_BURST_GENERATOR_DEFINES_SVH
`define DDS_TONE_BURST_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

`define DTBG_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("dtbg assertion failed");

`define DTBG_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("dtbg assertion failed");

`else

`define DTBG_ASSERT_IMPL(lbl, pre, post)

`define DTBG_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

// ===== design/dtbg_pkg.sv =====
`default_nettype none

package dtbg_pkg;

	localparam int TABLE_ADDR_BITS = 8;
	localparam int ADDR_DOWN = (TABLE_ADDR_BITS >= 8) ? TABLE_ADDR_BITS - 8 : 0;
	localparam int ADDR_UP = (TABLE_ADDR_BITS < 8) ? 8 - TABLE_ADDR_BITS : 0;

	localparam logic [11:0] RESET_STEP = 12'd461;
	localparam logic [15:0] RESET_LENGTH = 16'd3906;
	localparam logic [7:0] MID_LEVEL = 8'd128;
	localparam logic [3:0] MAX_SHIFT = 4'd8;
	localparam logic [31:0] STEP_SCALE = 32'd3242;
	localparam logic [31:0] STEP_OFFSET = 32'd30212096;

	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_UPDATE = 2'd1;
	localparam logic [1:0] REQ_BEEP = 2'd2;

	typedef enum logic [2:0] {
		REG_PITCH_INDEX = 3'd0,
		REG_TONE_RATE = 3'd1,
		REG_VOLUME_SHIFT = 3'd2,
		REG_TONE_LENGTH = 3'd3,
		REG_TONE_ENABLE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] beep_pitch;
		logic [15:0] beep_length;
	} in_item_t;

	typedef struct packed {
		logic [7:0] level;
		logic running;
		logic started;
		logic beep_rejected;
	} out_item_t;

	localparam logic [7:0] SINE_ROM [256] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd153, 8'd156, 8'd159, 8'd162, 8'd165, 8'd168, 8'd171, 8'd174,
		8'd177, 8'd180, 8'd182, 8'd185, 8'd188, 8'd191, 8'd194, 8'd196,
		8'd199, 8'd201, 8'd204, 8'd207, 8'd209, 8'd211, 8'd214, 8'd216,
		8'd218, 8'd220, 8'd223, 8'd225, 8'd227, 8'd229, 8'd231, 8'd232,
		8'd234, 8'd236, 8'd238, 8'd239, 8'd241, 8'd242, 8'd243, 8'd245,
		8'd246, 8'd247, 8'd248, 8'd249, 8'd250, 8'd251, 8'd252, 8'd253,
		8'd253, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd253,
		8'd253, 8'd252, 8'd251, 8'd251, 8'd250, 8'd249, 8'd248, 8'd247,
		8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
		8'd233, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd219,
		8'd217, 8'd215, 8'd213, 8'd210, 8'd208, 8'd205, 8'd203, 8'd200,
		8'd198, 8'd195, 8'd192, 8'd189, 8'd187, 8'd184, 8'd181, 8'd178,
		8'd175, 8'd172, 8'd169, 8'd166, 8'd163, 8'd160, 8'd157, 8'd154,
		8'd151, 8'd148, 8'd145, 8'd142, 8'd139, 8'd135, 8'd132, 8'd129,
		8'd126, 8'd123, 8'd120, 8'd116, 8'd113, 8'd110, 8'd107, 8'd104,
		8'd101, 8'd98, 8'd95, 8'd92, 8'd89, 8'd86, 8'd83, 8'd80,
		8'd77, 8'd74, 8'd71, 8'd68, 8'd66, 8'd63, 8'd60, 8'd57,
		8'd55, 8'd52, 8'd50, 8'd47, 8'd45, 8'd42, 8'd40, 8'd38,
		8'd36, 8'd33, 8'd31, 8'd29, 8'd27, 8'd25, 8'd23, 8'd22,
		8'd20, 8'd18, 8'd17, 8'd15, 8'd14, 8'd12, 8'd11, 8'd10,
		8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd4, 8'd3, 8'd2,
		8'd2, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd1, 8'd2,
		8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9,
		8'd10, 8'd12, 8'd13, 8'd14, 8'd16, 8'd17, 8'd19, 8'd21,
		8'd23, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd35, 8'd37,
		8'd39, 8'd41, 8'd44, 8'd46, 8'd48, 8'd51, 8'd54, 8'd56,
		8'd59, 8'd61, 8'd64, 8'd67, 8'd70, 8'd73, 8'd75, 8'd78,
		8'd81, 8'd84, 8'd87, 8'd90, 8'd93, 8'd96, 8'd99, 8'd102,
		8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124, 8'd128
	};

	function automatic logic [11:0] step_of(input logic [15:0] index);
		logic [31:0] prod;
		prod = 32'(index) * STEP_SCALE + STEP_OFFSET;
		return prod[27:16];
	endfunction

	function automatic logic [7:0] rom_at(input logic [15:0] phase);
		logic [15:0] addr;
		logic [15:0] idx;
		addr = phase >> (16 - TABLE_ADDR_BITS);
		idx = (TABLE_ADDR_BITS >= 8) ? (addr >> ADDR_DOWN) : (addr << ADDR_UP);
		return SINE_ROM[idx[7:0]];
	endfunction

	function automatic logic [7:0] level_of(input logic [7:0] sample, input logic [3:0] vol);
		logic [3:0] sh;
		logic [8:0] sum;
		sh = (vol > MAX_SHIFT) ? MAX_SHIFT : vol;
		sum = 9'(MID_LEVEL) - (9'(MID_LEVEL) >> sh) + (9'(sample) >> sh);
		return sum[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== design/dds_tone_burst_generator.sv =====
// Tone-burst generator built on direct digital synthesis.
// Request channel in_valid/in_stall/in_data: each request is a sample tick,
// an update tick or a beep request; every request yields exactly one result.
// Result channel out_valid/out_stall/out_data: level, running, started and
// beep_rejected as they stand after the request.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data: always ready; write
// only while no request is in flight.
// The input register takes the request, then the result register fed by the state
// update and the sine ROM lookup is loaded from it while the result side is free.
// Throughput: one request per cycle while the receiver does not stall; the state
// update and result of a request are combinational from its input register.
// When the receiver stalls, the result register holds and the input register
// takes one more request, then in_stall rises until the result is taken.
// Reset: asynchronous, active low; all but the data registers reset, the level
// reads 128 and the generator is idle, with no clearing pass.
`default_nettype none
`include "dds_tone_burst_generator_defines.svh"

module dds_tone_burst_generator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire dtbg_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output dtbg_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [2:0] cfg_index,
	input wire logic [15:0] cfg_data
);
	import dtbg_pkg::*;

	logic valid_s1;
	in_item_t item_s1;
	logic valid_s2;
	out_item_t item_s2;

	logic [15:0] pitch_index_q;
	logic [15:0] tone_rate_q;
	logic [3:0] volume_shift_q;
	logic [15:0] tone_length_q;
	logic tone_enable_q;

	logic [15:0] phase_acc_q;
	logic [11:0] phase_step_q;
	logic [15:0] burst_count_q;
	logic [15:0] burst_length_q;
	logic [15:0] rate_acc_q;
	logic active_q;
	logic beep_mode_q;
	logic [7:0] out_level_q;

	logic fire;
	logic out_free;
	logic cfg_we;

	logic [15:0] phase_acc_d;
	logic [11:0] phase_step_d;
	logic [15:0] burst_count_d;
	logic [15:0] burst_length_d;
	logic [15:0] rate_acc_d;
	logic active_d;
	logic beep_mode_d;
	logic [7:0] out_level_d;
	logic started_d;
	logic rejected_d;
	logic [15:0] count_inc;

	assign out_free = !valid_s2 || !out_stall;
	assign fire = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign out_valid = valid_s2;
	assign out_data = item_s2;
	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid && cfg_ready;
	assign count_inc = burst_count_q + 16'd1;

	always_comb begin
		phase_acc_d = phase_acc_q;
		phase_step_d = phase_step_q;
		burst_count_d = burst_count_q;
		burst_length_d = burst_length_q;
		rate_acc_d = rate_acc_q;
		active_d = active_q;
		beep_mode_d = beep_mode_q;
		out_level_d = out_level_q;
		started_d = 1'b0;
		rejected_d = 1'b0;
		case (item_s1.req_type)
			REQ_SAMPLE: begin
				if (active_q) begin
					burst_count_d = count_inc;
					if (count_inc < burst_length_q) begin
						out_level_d = level_of(rom_at(phase_acc_q), volume_shift_q);
						phase_acc_d = phase_acc_q + 16'(phase_step_q);
					end else begin
						active_d = 1'b0;
						phase_acc_d = '0;
						if (beep_mode_q) begin
							beep_mode_d = 1'b0;
							burst_length_d = tone_length_q;
						end
					end
				end
			end
			REQ_UPDATE: begin
				if (tone_enable_q) begin
					if (16'(16'd0 - rate_acc_q) < tone_rate_q) begin
						if (!beep_mode_q) begin
							phase_step_d = step_of(pitch_index_q);
						end
						burst_count_d = '0;
						active_d = 1'b1;
						started_d = 1'b1;
					end
					rate_acc_d = rate_acc_q + tone_rate_q;
				end
			end
			REQ_BEEP: begin
				if (active_q) begin
					rejected_d = 1'b1;
				end else begin
					phase_step_d = step_of(item_s1.beep_pitch);
					burst_length_d = item_s1.beep_length;
					burst_count_d = '0;
					active_d = 1'b1;
					beep_mode_d = 1'b1;
					started_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || fire) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= fire;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!valid_s1 || fire) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			item_s2.level <= out_level_d;
			item_s2.running <= active_d;
			item_s2.started <= started_d;
			item_s2.beep_rejected <= rejected_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_index_q <= '0;
			tone_rate_q <= '0;
			volume_shift_q <= '0;
			tone_length_q <= RESET_LENGTH;
			tone_enable_q <= 1'b0;
			phase_acc_q <= '0;
			phase_step_q <= RESET_STEP;
			burst_count_q <= '0;
			burst_length_q <= RESET_LENGTH;
			rate_acc_q <= '0;
			active_q <= 1'b0;
			beep_mode_q <= 1'b0;
			out_level_q <= MID_LEVEL;
		end else begin
			if (fire) begin
				phase_acc_q <= phase_acc_d;
				phase_step_q <= phase_step_d;
				burst_count_q <= burst_count_d;
				burst_length_q <= burst_length_d;
				rate_acc_q <= rate_acc_d;
				active_q <= active_d;
				beep_mode_q <= beep_mode_d;
				out_level_q <= out_level_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_PITCH_INDEX: pitch_index_q <= cfg_data;
					REG_TONE_RATE: tone_rate_q <= cfg_data;
					REG_VOLUME_SHIFT: volume_shift_q <= cfg_data[3:0];
					REG_TONE_LENGTH: begin
						tone_length_q <= cfg_data;
						if (!beep_mode_q) begin
							burst_length_q <= cfg_data;
						end
					end
					REG_TONE_ENABLE: tone_enable_q <= cfg_data[0];
					default: begin
					end
				endcase
			end
		end
	end

	`DTBG_ASSERT_IMPL(a_beep_implies_active, beep_mode_q, active_q)
	`DTBG_ASSERT_IMPL(a_idle_phase_zero, !active_q, phase_acc_q == 16'd0)
	`DTBG_ASSERT_IMPL(a_started_running, valid_s2 && item_s2.started,
		item_s2.running && !item_s2.beep_rejected)
	`DTBG_ASSERT_NEXT(a_fire_loads_result, fire, valid_s2)

endmodule

`default_nettype wire

// ===== bench/dds_tone_burst_generator_tb.sv =====
`timescale 1ns / 1ps

module dds_tone_burst_generator_tb;
	import dtbg_pkg::*;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam logic [2:0] REG_BEYOND = 3'd5;
	localparam int CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [15:0] cfg_data;

	// register shadows
	logic [15:0] set_pitch;
	logic [15:0] set_rate;
	logic [3:0] set_volume;
	logic [15:0] set_length;
	logic set_enable;

	// generator state
	logic [15:0] gen_phase;
	logic [11:0] gen_step;
	logic [15:0] gen_count;
	logic [15:0] gen_length;
	logic [15:0] gen_rate_acc;
	logic gen_active;
	logic gen_beep;
	logic [7:0] gen_level;

	out_item_t due_outputs[$];
	int mismatches;
	int cycle_count;
	int hold_request;

	dds_tone_burst_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [11:0] pitch_step(input logic [15:0] pitch);
		logic [31:0] scaled;
		scaled = {16'd0, pitch} * 32'd3242 + 32'd30212096;
		return scaled[27:16];
	endfunction

	// smaller tables drop the low address bits of the 256-entry ROM
	function automatic logic [7:0] sine_sample(input logic [15:0] phase);
		logic [7:0] keep;
		keep = 8'hFF << ADDR_UP;
		return SINE_ROM[phase[15:8] & keep];
	endfunction

	function automatic out_item_t predict_result(input in_item_t r);
		out_item_t res;
		logic [3:0] sh;
		logic [8:0] sum;
		logic [15:0] headroom;
		res = '0;
		case (r.req_type)
			REQ_SAMPLE: begin
				if (gen_active) begin
					gen_count = gen_count + 16'd1;
					if (gen_count < gen_length) begin
						sh = (set_volume > MAX_SHIFT) ? MAX_SHIFT : set_volume;
						sum = {1'b0, MID_LEVEL} - ({1'b0, MID_LEVEL} >> sh)
							+ ({1'b0, sine_sample(gen_phase)} >> sh);
						gen_level = sum[7:0];
						gen_phase = gen_phase + {4'd0, gen_step};
					end else begin
						gen_active = 1'b0;
						gen_phase = '0;
						if (gen_beep) begin
							gen_beep = 1'b0;
							gen_length = set_length;
						end
					end
				end
			end
			REQ_UPDATE: begin
				if (set_enable) begin
					headroom = 16'd0 - gen_rate_acc;
					if (headroom < set_rate) begin
						if (!gen_beep)
							gen_step = pitch_step(set_pitch);
						gen_count = '0;
						gen_active = 1'b1;
						res.started = 1'b1;
					end
					gen_rate_acc = gen_rate_acc + set_rate;
				end
			end
			REQ_BEEP: begin
				if (gen_active) begin
					res.beep_rejected = 1'b1;
				end else begin
					gen_step = pitch_step(r.beep_pitch);
					gen_length = r.beep_length;
					gen_count = '0;
					gen_active = 1'b1;
					gen_beep = 1'b1;
					res.started = 1'b1;
				end
			end
			default: ;
		endcase
		res.level = gen_level;
		res.running = gen_active;
		return res;
	endfunction

	task automatic offer_request(input logic [1:0] kind, input logic [15:0] pitch,
			input logic [15:0] len);
		in_item_t r;
		r.req_type = kind;
		r.beep_pitch = pitch;
		r.beep_length = len;
		in_valid <= 1'b1;
		in_data <= r;
		do @(posedge clk); while (in_stall);
		due_outputs.push_back(predict_result(r));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_PITCH_INDEX: set_pitch = val;
			REG_TONE_RATE: set_rate = val;
			REG_VOLUME_SHIFT: set_volume = val[3:0];
			REG_TONE_LENGTH: begin
				set_length = val;
				if (!gen_beep)
					gen_length = val;
			end
			REG_TONE_ENABLE: set_enable = val[0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [15:0] pitch, input logic [15:0] rate,
			input logic [15:0] vol, input logic [15:0] len, input logic [15:0] en);
		write_reg(REG_PITCH_INDEX, pitch);
		write_reg(REG_TONE_RATE, rate);
		write_reg(REG_VOLUME_SHIFT, vol);
		write_reg(REG_TONE_LENGTH, len);
		write_reg(REG_TONE_ENABLE, en);
	endtask

	task automatic test_idle_requests;
		offer_request(REQ_SAMPLE, 16'h0000, 16'h0000);
		offer_request(REQ_UPDATE, 16'hFFFF, 16'hFFFF);
		offer_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF);
		offer_request(REQ_BEEP, 16'h0000, 16'h0000);
		offer_request(REQ_SAMPLE, 16'h0000, 16'h0000);
		offer_request(REQ_BEEP, 16'hFFFF, 16'd3);
		offer_request(REQ_BEEP, 16'h0000, 16'h0000);
		repeat (4) offer_request(REQ_SAMPLE, 16'h5555, 16'hAAAA);
		drain();
	endtask

	task automatic test_register_writes;
		write_all(16'hFFFF, 16'hFFFF, 16'd15, 16'd0, 16'hFFFF);
		for (logic [2:0] i = REG_BEYOND; i != 3'd0; i++)
			write_reg(i, 16'($urandom));
		offer_request(REQ_UPDATE, 16'h0000, 16'h0000);
		offer_request(REQ_UPDATE, 16'h0000, 16'h0000);
		offer_request(REQ_SAMPLE, 16'h0000, 16'h0000);
		drain();
		write_reg(REG_VOLUME_SHIFT, 16'd8);
		write_reg(REG_TONE_LENGTH, 16'd2);
		offer_request(REQ_UPDATE, 16'h0000, 16'h0000);
		repeat (2) offer_request(REQ_SAMPLE, 16'h0000, 16'h0000);
		drain();
		write_reg(REG_TONE_ENABLE, 16'hFFFE);
		offer_request(REQ_UPDATE, 16'h0000, 16'h0000);
		drain();
	endtask

	task automatic test_retrigger_in_beep;
		write_all(16'h0000, 16'h4000, 16'd0, 16'd100, 16'd1);
		offer_request(REQ_BEEP, 16'h1234, 16'd50);
		repeat (2) offer_request(REQ_SAMPLE, 16'h0000, 16'h0000);
		drain();
		write_reg(REG_TONE_LENGTH, 16'd7);
		repeat (4) offer_request(REQ_UPDATE, 16'h0000, 16'h0000);
		repeat (3) offer_request(REQ_SAMPLE, 16'h0000, 16'h0000);
		offer_request(REQ_BEEP, 16'h0000, 16'd1);
		drain();
	endtask

	task automatic test_backpressure;
		hold_request = 300;
		repeat (40) offer_request(REQ_SAMPLE, 16'($urandom), 16'($urandom));
		drain();
	endtask

	task automatic test_random_traffic(input int count, input logic [15:0] pitch,
			input logic [15:0] rate, input logic [15:0] vol, input logic [15:0] len,
			input logic [15:0] en);
		int roll;
		int burst_left;
		int gap;
		bit steady;
		logic [1:0] kind;
		logic [15:0] bp;
		logic [15:0] bl;
		write_all(pitch, rate, vol, len, en);
		steady = ($urandom_range(0, 2) == 0);
		burst_left = $urandom_range(1, 20);
		repeat (count) begin
			roll = $urandom_range(0, 99);
			bp = 16'($urandom);
			bl = 16'($urandom);
			if (roll < 60) begin
				kind = REQ_SAMPLE;
			end else if (roll < 80) begin
				kind = REQ_UPDATE;
			end else if (roll < 96) begin
				kind = REQ_BEEP;
				if ($urandom_range(0, 7) != 0)
					bl = 16'($urandom_range(0, 40));
			end else begin
				kind = REQ_UNUSED;
			end
			offer_request(kind, bp, bl);
			burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = $urandom_range(0, 5);
				if (!steady && gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		drain();
	endtask

	initial begin : receiver_stall
		int hold_left;
		int mode;
		int mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					default: out_stall <= (cycle_count[2:0] >= 3'd5);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: level %0d running %0b started %0b rejected %0b",
						out_data.level, out_data.running, out_data.started,
						out_data.beep_rejected);
			end else begin
				want = due_outputs.pop_front();
				if (out_data.level !== want.level || out_data.running !== want.running
						|| out_data.started !== want.started
						|| out_data.beep_rejected !== want.beep_rejected) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected level %0d running %0b started %0b ",
							"rejected %0b, got level %0d running %0b started %0b rejected %0b"},
							want.level, want.running, want.started, want.beep_rejected,
							out_data.level, out_data.running, out_data.started,
							out_data.beep_rejected);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		cycle_count = 0;
		hold_request = 0;
		set_pitch = '0;
		set_rate = '0;
		set_volume = '0;
		set_length = RESET_LENGTH;
		set_enable = 1'b0;
		gen_phase = '0;
		gen_step = RESET_STEP;
		gen_count = '0;
		gen_length = RESET_LENGTH;
		gen_rate_acc = '0;
		gen_active = 1'b0;
		gen_beep = 1'b0;
		gen_level = MID_LEVEL;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_requests();
		test_register_writes();
		test_retrigger_in_beep();
		test_backpressure();
		test_random_traffic(140, 16'($urandom), 16'h2000, 16'd0, 16'd20, 16'd1);
		test_random_traffic(140, 16'hFFFF, 16'hFFFF, 16'd8, 16'd0, 16'd1);
		test_random_traffic(130, 16'h0000, 16'h0001, 16'd3, 16'hFFFF, 16'd1);
		test_random_traffic(130, 16'($urandom), 16'($urandom), 16'($urandom_range(9, 15)),
			16'($urandom_range(1, 60)), 16'd0);
		test_random_traffic(130, 16'($urandom), 16'h8000, 16'd1, 16'd5, 16'd1);
		test_random_traffic(130, 16'($urandom), 16'($urandom_range(1, 65535)),
			16'($urandom_range(0, 8)), 16'($urandom_range(0, 300)), 16'd1);

		drain();
		if (mismatches == 0 && due_outputs.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
